// ===== rtl/rbc_pkg.sv =====
package rbc_pkg;

    localparam int ATTEMPT_BITS_DEF = 16;
    localparam int DELAY_BITS_DEF   = 31;
    localparam int TOTAL_BITS_DEF   = 32;

    localparam int POLICY_W   = 2;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_BASE   = 2'd2,
        CFG_CAP    = 2'd3
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_DISCONNECT = 3'd0,
        REQ_SUCCESS    = 3'd1,
        REQ_FAILURE    = 3'd2,
        REQ_CANCEL     = 3'd3,
        REQ_RESET      = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE      = 2'd0,
        ST_WAITING   = 2'd1,
        ST_CONNECTED = 2'd2,
        ST_GAVE_UP   = 2'd3
    } t_status;

    localparam logic [POLICY_W-1:0] POL_NEVER  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_ALWAYS = 2'd2;

    localparam logic [POLICY_W-1:0]   RST_POLICY = 2'd1;
    localparam logic [LIMIT_W-1:0]    RST_LIMIT  = 16'd0;
    localparam logic [CFG_DATA_W-1:0] RST_BASE   = 31'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_CAP    = 31'd60000;

    typedef struct packed {
        logic [POLICY_W-1:0]   policy;
        logic [LIMIT_W-1:0]    limit;
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] cap;
    } t_cfg;

endpackage

// ===== rtl/rbc_req_if.sv =====
interface rbc_req_if;
    logic                     valid;
    logic                     ready;
    logic [rbc_pkg::REQ_W-1:0] req_type;
    logic                     clean_exit;

    modport source (output valid, output req_type, output clean_exit, input ready);
    modport sink (input valid, input req_type, input clean_exit, output ready);
endinterface

// ===== rtl/rbc_res_if.sv =====
interface rbc_res_if #(
    parameter int ATTEMPT_BITS = rbc_pkg::ATTEMPT_BITS_DEF,
    parameter int DELAY_BITS   = rbc_pkg::DELAY_BITS_DEF,
    parameter int TOTAL_BITS   = rbc_pkg::TOTAL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         retry_go;
    logic [rbc_pkg::STATUS_W-1:0] conn_status;
    logic [ATTEMPT_BITS-1:0]      attempts_now;
    logic [DELAY_BITS-1:0]        delay_now;
    logic [TOTAL_BITS-1:0]        reconnects_seen;
    logic [TOTAL_BITS-1:0]        failures_seen;

    modport source (
        output valid, output retry_go, output conn_status, output attempts_now,
        output delay_now, output reconnects_seen, output failures_seen,
        input ready
    );
    modport sink (
        input valid, input retry_go, input conn_status, input attempts_now,
        input delay_now, input reconnects_seen, input failures_seen,
        output ready
    );
endinterface

// ===== rtl/reconnect_backoff_controller_top.sv =====
// Reconnect backoff controller. Each input item is one event (link dropped with a clean-exit
// flag, reconnect succeeded, reconnect failed, cancel, soft reset) and yields exactly one result
// item with the retry decision, the connection state, the attempt count, the backoff delay and
// the two saturating totals. The logic in front of the state registers, which also hold the
// result, processes an event, so one item is accepted per clock unless a result waits untaken;
// the result is valid the cycle after acceptance and a new item is taken in the same cycle a
// waiting result is taken. A failure doubles the delay and clamps it to the cap. Configuration
// writes take effect on the next cycle and should only be made while no result is outstanding.
module reconnect_backoff_controller_top #(
    parameter int ATTEMPT_BITS = rbc_pkg::ATTEMPT_BITS_DEF,
    parameter int DELAY_BITS   = rbc_pkg::DELAY_BITS_DEF,
    parameter int TOTAL_BITS   = rbc_pkg::TOTAL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rbc_req_if.sink                        i_req,
    rbc_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CMP_W = (ATTEMPT_BITS > rbc_pkg::LIMIT_W) ? ATTEMPT_BITS : rbc_pkg::LIMIT_W;
    localparam int DLY_W = (DELAY_BITS > rbc_pkg::CFG_DATA_W) ? DELAY_BITS : rbc_pkg::CFG_DATA_W;
    localparam logic [DLY_W-1:0] DELAY_MAX = DLY_W'({DELAY_BITS{1'b1}});

    function automatic logic [DELAY_BITS-1:0] f_clamp(input logic [rbc_pkg::CFG_DATA_W-1:0] v);
        logic [DLY_W-1:0] ext;
        ext = DLY_W'(v);
        if (ext > DELAY_MAX) begin
            f_clamp = {DELAY_BITS{1'b1}};
        end else begin
            f_clamp = DELAY_BITS'(ext);
        end
    endfunction

    rbc_pkg::t_cfg w_cfg;

    rbc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    logic [rbc_pkg::STATUS_W-1:0] r_state, n_state;
    logic [ATTEMPT_BITS-1:0]      r_att, n_att;
    logic [DELAY_BITS-1:0]        r_delay, n_delay;
    logic [TOTAL_BITS-1:0]        r_recon, n_recon;
    logic [TOTAL_BITS-1:0]        r_fail, n_fail;
    logic                         r_go, n_go;
    logic                         r_out_valid;

    logic                         w_accept;
    logic [ATTEMPT_BITS-1:0]      w_att_inc;
    logic                         w_limit_now;
    logic                         w_limit_inc;
    logic [DELAY_BITS:0]          w_dbl;
    logic [DELAY_BITS-1:0]        w_dbl_sat;
    logic [DELAY_BITS-1:0]        w_base_dly;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_att_inc   = (r_att == {ATTEMPT_BITS{1'b1}}) ? r_att : r_att + 1'b1;
    assign w_limit_now = (w_cfg.limit != '0) && (CMP_W'(r_att) >= CMP_W'(w_cfg.limit));
    assign w_limit_inc = (w_cfg.limit != '0) && (CMP_W'(w_att_inc) >= CMP_W'(w_cfg.limit));
    assign w_dbl       = {r_delay, 1'b0};
    assign w_dbl_sat   = w_dbl[DELAY_BITS] ? {DELAY_BITS{1'b1}} : w_dbl[DELAY_BITS-1:0];
    assign w_base_dly  = f_clamp(w_cfg.base);

    always_comb begin
        n_state = r_state;
        n_att   = r_att;
        n_delay = r_delay;
        n_recon = r_recon;
        n_fail  = r_fail;
        n_go    = 1'b0;
        case (i_req.req_type)
            rbc_pkg::REQ_DISCONNECT: begin
                if (w_cfg.policy != rbc_pkg::POL_NEVER &&
                    (!i_req.clean_exit || w_cfg.policy == rbc_pkg::POL_ALWAYS)) begin
                    if (w_limit_now) begin
                        n_state = rbc_pkg::ST_GAVE_UP;
                    end else begin
                        n_state = rbc_pkg::ST_WAITING;
                        n_go    = 1'b1;
                    end
                end
            end
            rbc_pkg::REQ_SUCCESS: begin
                n_state = rbc_pkg::ST_CONNECTED;
                n_att   = '0;
                n_delay = w_base_dly;
                n_recon = (r_recon == {TOTAL_BITS{1'b1}}) ? r_recon : r_recon + 1'b1;
            end
            rbc_pkg::REQ_FAILURE: begin
                n_att  = w_att_inc;
                n_fail = (r_fail == {TOTAL_BITS{1'b1}}) ? r_fail : r_fail + 1'b1;
                if (DLY_W'(w_dbl_sat) > DLY_W'(w_cfg.cap)) begin
                    n_delay = f_clamp(w_cfg.cap);
                end else begin
                    n_delay = w_dbl_sat;
                end
                n_state = w_limit_inc ? rbc_pkg::ST_GAVE_UP : rbc_pkg::ST_WAITING;
            end
            rbc_pkg::REQ_CANCEL: begin
                n_state = rbc_pkg::ST_IDLE;
                n_att   = '0;
                n_delay = w_base_dly;
            end
            rbc_pkg::REQ_RESET: begin
                n_state = rbc_pkg::ST_IDLE;
                n_att   = '0;
                n_delay = w_base_dly;
                n_recon = '0;
                n_fail  = '0;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbc_pkg::ST_IDLE;
            r_att       <= '0;
            r_delay     <= f_clamp(rbc_pkg::RST_BASE);
            r_recon     <= '0;
            r_fail      <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_state     <= n_state;
            r_att       <= n_att;
            r_delay     <= n_delay;
            r_recon     <= n_recon;
            r_fail      <= n_fail;
            r_go        <= n_go;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The state only changes when an item is accepted, so the state registers hold the result.
    assign o_res.valid           = r_out_valid;
    assign o_res.retry_go        = r_go;
    assign o_res.conn_status     = r_state;
    assign o_res.attempts_now    = r_att;
    assign o_res.delay_now       = r_delay;
    assign o_res.reconnects_seen = r_recon;
    assign o_res.failures_seen   = r_fail;

endmodule

// ===== rtl/rbc_cfg.sv =====
module rbc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rbc_pkg::t_cfg                    o_cfg
);

    rbc_pkg::t_cfg r_cfg;
    rbc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                rbc_pkg::CFG_POLICY: n_cfg.policy = i_cfg_data[rbc_pkg::POLICY_W-1:0];
                rbc_pkg::CFG_LIMIT:  n_cfg.limit  = i_cfg_data[rbc_pkg::LIMIT_W-1:0];
                rbc_pkg::CFG_BASE:   n_cfg.base   = i_cfg_data;
                rbc_pkg::CFG_CAP:    n_cfg.cap    = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy <= rbc_pkg::RST_POLICY;
            r_cfg.limit  <= rbc_pkg::RST_LIMIT;
            r_cfg.base   <= rbc_pkg::RST_BASE;
            r_cfg.cap    <= rbc_pkg::RST_CAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== dv/tb_reconnect_backoff_controller_top.sv =====
`timescale 1ns / 100ps

module tb_reconnect_backoff_controller_top;
    import rbc_pkg::*;

    localparam int ATT_W = ATTEMPT_BITS_DEF;
    localparam int DLY_W = DELAY_BITS_DEF;
    localparam int TOT_W = TOTAL_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int PHASE_EVENTS = 240;
    localparam int PLAN_LEN = 37;

    localparam logic [REQ_W-1:0]    REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [REQ_W-1:0]    REQ_UNKNOWN_LAST  = 3'd7;
    localparam logic [POLICY_W-1:0] POL_UNUSED        = 2'd3;

    typedef struct packed {
        logic             go;
        t_status          status;
        logic [ATT_W-1:0] attempts;
        logic [DLY_W-1:0] delay;
        logic [TOT_W-1:0] reconnects;
        logic [TOT_W-1:0] failures;
    } link_report_t;

    typedef struct packed {
        logic                  is_cfg;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        logic [REQ_W-1:0]      code;
        logic                  clean;
        logic                  typed;
        link_report_t          want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_cfg_idx cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rbc_req_if req_ch ();
    rbc_res_if res_ch ();

    reconnect_backoff_controller_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predicted register and link state.
    logic [POLICY_W-1:0] pred_policy = RST_POLICY;
    logic [LIMIT_W-1:0]  pred_limit  = RST_LIMIT;
    logic [DLY_W-1:0]    pred_base   = RST_BASE;
    logic [DLY_W-1:0]    pred_cap    = RST_CAP;
    t_status             link_state  = ST_IDLE;
    logic [ATT_W-1:0]    attempt_cnt = '0;
    logic [DLY_W-1:0]    backoff     = RST_BASE;
    logic [TOT_W-1:0]    reconnect_tot = '0;
    logic [TOT_W-1:0]    failure_tot   = '0;

    link_report_t awaited_reports[$];
    logic         fixed_on;
    link_report_t fixed_val;
    int issued = 0;
    int received = 0;
    int errors = 0;
    int cycles = 0;
    int cfg_writes = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    plan_row_t plan [PLAN_LEN];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic limit_hit();
        return pred_limit != '0 && attempt_cnt >= pred_limit;
    endfunction

    function automatic link_report_t advance_link(logic [REQ_W-1:0] code, logic clean);
        link_report_t r;
        logic [DLY_W:0] doubled;
        logic [DLY_W-1:0] next_delay;
        r.go = 1'b0;
        case (code)
            REQ_DISCONNECT: begin
                if (pred_policy != POL_NEVER && !(clean && pred_policy != POL_ALWAYS)) begin
                    if (limit_hit()) begin
                        link_state = ST_GAVE_UP;
                    end else begin
                        link_state = ST_WAITING;
                        r.go = 1'b1;
                    end
                end
            end
            REQ_SUCCESS: begin
                link_state = ST_CONNECTED;
                attempt_cnt = '0;
                backoff = pred_base;
                if (reconnect_tot != '1) reconnect_tot = reconnect_tot + 1'b1;
            end
            REQ_FAILURE: begin
                if (attempt_cnt != '1) attempt_cnt = attempt_cnt + 1'b1;
                if (failure_tot != '1) failure_tot = failure_tot + 1'b1;
                doubled = {backoff, 1'b0};
                next_delay = doubled[DLY_W] ? '1 : doubled[DLY_W-1:0];
                if (next_delay > pred_cap) next_delay = pred_cap;
                backoff = next_delay;
                link_state = limit_hit() ? ST_GAVE_UP : ST_WAITING;
            end
            REQ_CANCEL: begin
                link_state = ST_IDLE;
                attempt_cnt = '0;
                backoff = pred_base;
            end
            REQ_RESET: begin
                link_state = ST_IDLE;
                attempt_cnt = '0;
                backoff = pred_base;
                reconnect_tot = '0;
                failure_tot = '0;
            end
            default: begin
            end
        endcase
        r.status = link_state;
        r.attempts = attempt_cnt;
        r.delay = backoff;
        r.reconnects = reconnect_tot;
        r.failures = failure_tot;
        return r;
    endfunction

    task automatic report(string what, logic [TOT_W-1:0] got_v, logic [TOT_W-1:0] want_v);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got_v, want_v, cycles);
        errors++;
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycles,
                     awaited_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        link_report_t got;
        link_report_t want;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_POLICY: pred_policy = cfg_data[POLICY_W-1:0];
                    CFG_LIMIT:  pred_limit = cfg_data[LIMIT_W-1:0];
                    CFG_BASE:   pred_base = cfg_data;
                    CFG_CAP:    pred_cap = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                want = advance_link(req_ch.req_type, req_ch.clean_exit);
                if (fixed_on) want = fixed_val;
                awaited_reports.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                received++;
                got.go = res_ch.retry_go;
                got.status = t_status'(res_ch.conn_status);
                got.attempts = res_ch.attempts_now;
                got.delay = res_ch.delay_now;
                got.reconnects = res_ch.reconnects_seen;
                got.failures = res_ch.failures_seen;
                if (awaited_reports.size() == 0) begin
                    report("result with nothing pending, status", got.status, 0);
                end else begin
                    want = awaited_reports.pop_front();
                    if (got.go !== want.go) report("retry_go", got.go, want.go);
                    if (got.status !== want.status)
                        report("conn_status", got.status, want.status);
                    if (got.attempts !== want.attempts)
                        report("attempts_now", got.attempts, want.attempts);
                    if (got.delay !== want.delay) report("delay_now", got.delay, want.delay);
                    if (got.reconnects !== want.reconnects)
                        report("reconnects_seen", got.reconnects, want.reconnects);
                    if (got.failures !== want.failures)
                        report("failures_seen", got.failures, want.failures);
                end
            end
        end
    end

    task automatic send_event(logic [REQ_W-1:0] code, logic clean, logic typed,
                              link_report_t want);
        cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= code;
        req_ch.clean_exit <= clean;
        fixed_on <= typed;
        fixed_val <= want;
        issued++;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Registers change only once every outstanding result has come back.
    task automatic drive_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        req_ch.valid <= 1'b0;
        while (received != issued) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        cfg_writes++;
        @(posedge clk);
    endtask

    // Mostly whole sessions: a drop, a run of failed attempts, then success, cancel or neither.
    task automatic run_sessions(int target);
        int pick;
        logic [REQ_W-1:0] code;
        while (issued < target) begin
            if ($urandom_range(0, 99) < 80) begin
                send_event(REQ_DISCONNECT, $urandom_range(0, 3) == 0, 1'b0, '0);
                repeat ($urandom_range(0, 7))
                    send_event(REQ_FAILURE, 1'($urandom_range(0, 1)), 1'b0, '0);
                pick = $urandom_range(0, 99);
                if (pick < 60) send_event(REQ_SUCCESS, 1'($urandom_range(0, 1)), 1'b0, '0);
                else if (pick < 85)
                    send_event(REQ_CANCEL, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    code = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
                else if (pick < 20) code = REQ_RESET;
                else code = REQ_W'($urandom_range(REQ_DISCONNECT, REQ_CANCEL));
                send_event(code, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
    endtask

    function automatic plan_row_t row_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic plan_row_t row_event(logic [REQ_W-1:0] code, logic clean);
        plan_row_t r;
        r = '0;
        r.code = code;
        r.clean = clean;
        return r;
    endfunction

    function automatic plan_row_t row_checked(logic [REQ_W-1:0] code, logic clean, logic go,
                                              t_status status, logic [ATT_W-1:0] att,
                                              logic [DLY_W-1:0] dly, logic [TOT_W-1:0] rec,
                                              logic [TOT_W-1:0] fail);
        plan_row_t r;
        r = row_event(code, clean);
        r.typed = 1'b1;
        r.want = '{go, status, att, dly, rec, fail};
        return r;
    endfunction

    initial begin
        logic [POLICY_W-1:0] pol;
        logic [LIMIT_W-1:0] lim;
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] cap;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_POLICY;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_DISCONNECT;
        req_ch.clean_exit <= 1'b0;
        fixed_on <= 1'b0;
        fixed_val <= '0;

        plan = '{
            row_checked(REQ_DISCONNECT, 1'b1, 1'b0, ST_IDLE, 0, 1000, 0, 0),
            row_checked(REQ_DISCONNECT, 1'b0, 1'b1, ST_WAITING, 0, 1000, 0, 0),
            row_checked(REQ_FAILURE, 1'b0, 1'b0, ST_WAITING, 1, 2000, 0, 1),
            row_checked(REQ_FAILURE, 1'b1, 1'b0, ST_WAITING, 2, 4000, 0, 2),
            row_checked(REQ_SUCCESS, 1'b0, 1'b0, ST_CONNECTED, 0, 1000, 1, 2),
            row_checked(REQ_CANCEL, 1'b1, 1'b0, ST_IDLE, 0, 1000, 1, 2),
            row_checked(REQ_UNKNOWN_FIRST, 1'b0, 1'b0, ST_IDLE, 0, 1000, 1, 2),
            row_checked(REQ_UNKNOWN_LAST, 1'b1, 1'b0, ST_IDLE, 0, 1000, 1, 2),
            row_checked(REQ_RESET, 1'b1, 1'b0, ST_IDLE, 0, 1000, 0, 0),
            row_event(REQ_FAILURE, 1'b0),
            row_event(REQ_FAILURE, 1'b1),
            row_event(REQ_FAILURE, 1'b0),
            row_event(REQ_FAILURE, 1'b1),
            row_event(REQ_FAILURE, 1'b0),
            row_event(REQ_FAILURE, 1'b1),
            row_cfg(CFG_POLICY, POL_ALWAYS),
            row_cfg(CFG_LIMIT, 2),
            row_event(REQ_DISCONNECT, 1'b0),
            row_event(REQ_CANCEL, 1'b0),
            row_event(REQ_DISCONNECT, 1'b1),
            row_event(REQ_FAILURE, 1'b0),
            row_event(REQ_FAILURE, 1'b1),
            row_cfg(CFG_POLICY, POL_NEVER),
            row_event(REQ_DISCONNECT, 1'b0),
            row_cfg(CFG_POLICY, POL_UNUSED),
            row_cfg(CFG_LIMIT, 0),
            row_event(REQ_DISCONNECT, 1'b1),
            row_event(REQ_DISCONNECT, 1'b0),
            row_cfg(CFG_BASE, 31'h7FFF_FFFF),
            row_cfg(CFG_CAP, 31'h7FFF_FFFF),
            row_checked(REQ_RESET, 1'b0, 1'b0, ST_IDLE, 0, 31'h7FFF_FFFF, 0, 0),
            row_checked(REQ_FAILURE, 1'b0, 1'b0, ST_WAITING, 1, 31'h7FFF_FFFF, 0, 1),
            row_cfg(CFG_BASE, 0),
            row_cfg(CFG_CAP, 0),
            row_cfg(CFG_LIMIT, 16'hFFFF),
            row_event(REQ_SUCCESS, 1'b1),
            row_event(REQ_FAILURE, 1'b0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) drive_cfg(plan[k].idx, plan[k].data);
            else send_event(plan[k].code, plan[k].clean, plan[k].typed, plan[k].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    pol = RST_POLICY;
                    lim = RST_LIMIT;
                    base = RST_BASE;
                    cap = RST_CAP;
                end
                1: begin
                    pol = POL_ALWAYS;
                    lim = '1;
                    base = '1;
                    cap = '1;
                end
                2: begin
                    pol = POL_NEVER;
                    lim = 1;
                    base = '0;
                    cap = '0;
                end
                3: begin
                    pol = POL_UNUSED;
                    lim = 3;
                    base = 1;
                    cap = 1000;
                end
                default: begin
                    pol = POLICY_W'($urandom_range(0, 3));
                    lim = LIMIT_W'($urandom_range(0, 6));
                    base = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 5000)
                                                            : $urandom());
                    cap = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 200000)
                                                           : $urandom());
                end
            endcase
            drive_cfg(CFG_POLICY, CFG_DATA_W'(pol));
            drive_cfg(CFG_LIMIT, CFG_DATA_W'(lim));
            drive_cfg(CFG_BASE, base);
            drive_cfg(CFG_CAP, cap);
            gap_pct = (p % 4 == 1) ? 49 : (p % 4 == 3) ? 19 : 0;
            stall_pct = (p % 4 == 2) ? 49 : (p % 4 == 3) ? 19 : 0;
            run_sessions(issued + PHASE_EVENTS);
        end

        req_ch.valid <= 1'b0;
        while (received != issued) @(posedge clk);
        repeat (5) @(posedge clk);
        if (awaited_reports.size() != 0) report("results never delivered", awaited_reports.size(), 0);

        $display("Ran %0d events, %0d of them from the directed table, under %0d register writes.",
                 issued, PLAN_LEN - 10, cfg_writes);
        $display("Random sessions ran with no idling, sender gaps, receiver stalls and both.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rbc_pkg.sv
rtl/rbc_req_if.sv
rtl/rbc_res_if.sv
rtl/rbc_cfg.sv
rtl/reconnect_backoff_controller_top.sv
dv/tb_reconnect_backoff_controller_top.sv
